FILE: hw/rtl/tkn_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Tokenizer package
// Shared types, codes and character helpers for the byte stream tokenizer.
// ============================================================================
package tkn_pkg;

    // Characters held in one row of the name buffer, one byte lane each.
    localparam int LANES = 8;
    // Width of a name length carried in a command (holds the largest limit).
    localparam int LEN_FIELD_W = 8;
    // Entries in the command queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_W     = 8'h77;

    typedef enum logic [2:0] {
        KIND_EOF   = 3'd0,
        KIND_WHILE = 3'd1,
        KIND_ID    = 3'd2,
        KIND_NUM   = 3'd3,
        KIND_OP    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MD_IDLE = 2'd0,
        MD_NUM  = 2'd1,
        MD_ID   = 2'd2
    } t_mode;

    // What the pending token turns into when it is flushed.
    typedef enum logic [1:0] {
        FL_NONE  = 2'd0,
        FL_NUM   = 2'd1,
        FL_ID    = 2'd2,
        FL_WHILE = 2'd3
    } t_flush;

    // The single-word token that follows the flush, if any.
    typedef enum logic [1:0] {
        TL_NONE = 2'd0,
        TL_EOF  = 2'd1,
        TL_OP   = 2'd2
    } t_tail;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_CHUNK = 2'd1,
        BK_TAIL  = 2'd2
    } t_bk_state;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        t_kind       token_kind;
        logic [31:0] number_value;
        logic [7:0]  operator_byte;
        logic [63:0] text_chunk;
        logic [3:0]  chunk_bytes;
        logic        token_done;
        logic        run_last;
    } t_out_word;

    // One entry per input byte that produces tokens.
    typedef struct packed {
        t_flush                 flush;
        logic [31:0]            number_value;
        logic [LEN_FIELD_W-1:0] id_len;
        t_tail                  tail;
        logic [7:0]             op_byte;
    } t_cmd;

    typedef struct packed {
        logic id_done;
        logic reading;
    } t_bk_status;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= 8'h39);
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c == CHAR_UNDER);
    endfunction

    // Character of the keyword "while" at a given position.
    function automatic logic [7:0] kw_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CHAR_W;
            3'd1:    ch = 8'h68;
            3'd2:    ch = 8'h69;
            3'd3:    ch = 8'h6C;
            3'd4:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_out_word single_word(input t_kind kind, input logic [31:0] num,
                                              input logic [7:0] op, input logic last);
        t_out_word w;
        w = '0;
        w.token_kind    = kind;
        w.number_value  = num;
        w.operator_byte = op;
        w.token_done    = 1'b1;
        w.run_last      = last;
        return w;
    endfunction

    function automatic t_out_word tail_word(input t_tail tail, input logic [7:0] op);
        t_out_word w;
        if (tail == TL_OP) begin
            w = single_word(KIND_OP, 32'd0, op, 1'b1);
        end else begin
            w = single_word(KIND_EOF, 32'd0, 8'd0, 1'b1);
        end
        return w;
    endfunction

endpackage

FILE: hw/rtl/tkn_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module tkn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/tkn_front.sv
`timescale 1ns / 1ps
// ============================================================================
// Tokenizer front end
// Accepts bytes, tracks the pending token and queues token commands.
// ============================================================================
module tkn_front #(
    parameter int KEPT_CHARS = 63,
    localparam int LEN_W = $clog2(KEPT_CHARS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tkn_pkg::t_in_word  i_in_word,
    input  logic               i_q_full,
    output logic               o_q_push,
    output tkn_pkg::t_cmd      o_q_cmd,
    input  logic               i_id_done,
    output logic               o_id_busy,
    output logic               o_wr_en,
    output logic [LEN_W-1:0]   o_wr_idx,
    output logic [7:0]         o_wr_data
);

    tkn_pkg::t_mode    r_mode, n_mode;
    logic [31:0]       r_acc, n_acc;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_wok, n_wok;
    logic              r_id_busy;

    logic [7:0]        c;
    logic              eot;
    logic              c_digit;
    logic              c_word;
    logic              accept;
    logic              starts_name;
    tkn_pkg::t_flush   flush_kind;
    tkn_pkg::t_cmd     cmd;

    assign c       = i_in_word.text_byte;
    assign eot     = i_in_word.end_of_text || (c == 8'd0);
    assign c_digit = tkn_pkg::is_digit(c);
    assign c_word  = tkn_pkg::is_word_start(c);

    // A new name would overwrite the buffer while the back still reads it.
    assign starts_name = !eot && c_word && (r_mode != tkn_pkg::MD_ID);
    assign o_in_stall  = i_q_full || (r_id_busy && starts_name);
    assign accept      = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (r_mode)
            tkn_pkg::MD_NUM: flush_kind = tkn_pkg::FL_NUM;
            tkn_pkg::MD_ID: begin
                flush_kind = (r_len == LEN_W'(5) && r_wok) ? tkn_pkg::FL_WHILE
                                                           : tkn_pkg::FL_ID;
            end
            default:         flush_kind = tkn_pkg::FL_NONE;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_len     = r_len;
        n_wok     = r_wok;
        cmd       = '0;
        o_q_push  = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_idx  = r_len;
        o_wr_data = c;

        cmd.number_value = r_acc;
        cmd.id_len       = tkn_pkg::LEN_FIELD_W'(r_len);
        cmd.op_byte      = c;

        if (accept) begin
            priority if (eot) begin
                cmd.flush = flush_kind;
                cmd.tail  = tkn_pkg::TL_EOF;
                o_q_push  = 1'b1;
                n_mode    = tkn_pkg::MD_IDLE;
                n_acc     = 32'd0;
                n_len     = '0;
            end else if (r_mode == tkn_pkg::MD_NUM && c_digit) begin
                n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, c[3:0]};
            end else if (r_mode == tkn_pkg::MD_ID && (c_word || c_digit)) begin
                if (r_len < LEN_W'(KEPT_CHARS)) begin
                    o_wr_en = 1'b1;
                    n_len   = r_len + 1'b1;
                    n_wok   = r_wok && ((r_len >= LEN_W'(5)) ||
                                        (c == tkn_pkg::kw_char(r_len[2:0])));
                end
            end else begin
                cmd.flush = flush_kind;
                n_mode    = tkn_pkg::MD_IDLE;
                n_acc     = 32'd0;
                n_len     = '0;
                priority if (tkn_pkg::is_space(c)) begin
                    cmd.tail = tkn_pkg::TL_NONE;
                end else if (c_digit) begin
                    n_mode = tkn_pkg::MD_NUM;
                    n_acc  = {28'd0, c[3:0]};
                end else if (c_word) begin
                    n_mode   = tkn_pkg::MD_ID;
                    o_wr_en  = 1'b1;
                    o_wr_idx = '0;
                    n_len    = LEN_W'(1);
                    n_wok    = (c == tkn_pkg::CHAR_W);
                end else begin
                    cmd.tail = tkn_pkg::TL_OP;
                end
                o_q_push = (cmd.flush != tkn_pkg::FL_NONE) || (cmd.tail != tkn_pkg::TL_NONE);
            end
        end
        o_q_cmd = cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tkn_pkg::MD_IDLE;
            r_acc     <= 32'd0;
            r_len     <= '0;
            r_wok     <= 1'b0;
            r_id_busy <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_len  <= n_len;
            r_wok  <= n_wok;
            if (o_q_push && cmd.flush == tkn_pkg::FL_ID) begin
                r_id_busy <= 1'b1;
            end else if (i_id_done) begin
                r_id_busy <= 1'b0;
            end
        end
    end

    assign o_id_busy = r_id_busy;

endmodule

FILE: hw/rtl/tkn_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// Command queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
module tkn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tkn_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tkn_pkg::t_cmd o_cmd
);

    tkn_pkg::t_cmd                r_mem [tkn_pkg::Q_DEPTH];
    logic [tkn_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [tkn_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [tkn_pkg::Q_CNT_W-1:0]  r_count;

    assign o_full  = (r_count == tkn_pkg::Q_CNT_W'(tkn_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/tkn_back.sv
`timescale 1ns / 1ps
// ============================================================================
// Tokenizer back end
// Turns queued commands into output words, reading names row by row.
// ============================================================================
module tkn_back #(
    parameter int KEPT_CHARS = 63,
    localparam int LEN_W = $clog2(KEPT_CHARS + 1),
    localparam int ROWS  = (KEPT_CHARS + tkn_pkg::LANES - 1) / tkn_pkg::LANES,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  tkn_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_rd_en,
    output logic [ROW_W-1:0]             o_rd_row,
    input  logic [tkn_pkg::LANES-1:0][7:0] i_rd_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tkn_pkg::t_out_word           o_out_word,
    output tkn_pkg::t_bk_status          o_status
);

    tkn_pkg::t_bk_state  r_state, n_state;
    tkn_pkg::t_cmd       r_cmd, n_cmd;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [LEN_W-1:0]    r_left, n_left;
    logic                r_out_valid;
    tkn_pkg::t_out_word  r_word, n_word;

    logic                slot_free;
    logic                load;
    logic                last_chunk;
    logic [3:0]          cnt;
    logic [63:0]         chunk;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign last_chunk = (r_left <= LEN_W'(tkn_pkg::LANES));
    assign cnt        = last_chunk ? 4'(r_left) : 4'(tkn_pkg::LANES);

    // Bytes past the end of the name read as zero.
    always_comb begin
        for (int i = 0; i < tkn_pkg::LANES; i++) begin
            chunk[i*8 +: 8] = (i < int'(cnt)) ? i_rd_data[i] : 8'h00;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_cmd            = r_cmd;
        n_row            = r_row;
        n_left           = r_left;
        n_word           = r_word;
        load             = 1'b0;
        o_q_pop          = 1'b0;
        o_rd_en          = 1'b0;
        o_rd_row         = r_row;
        o_status.id_done = 1'b0;
        o_status.reading = (r_state == tkn_pkg::BK_CHUNK);

        unique case (r_state)
            tkn_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.flush)
                        tkn_pkg::FL_ID: begin
                            o_q_pop  = 1'b1;
                            n_cmd    = i_q_cmd;
                            o_rd_en  = 1'b1;
                            o_rd_row = '0;
                            n_row    = '0;
                            n_left   = LEN_W'(i_q_cmd.id_len);
                            n_state  = tkn_pkg::BK_CHUNK;
                        end
                        tkn_pkg::FL_NUM, tkn_pkg::FL_WHILE: begin
                            if (slot_free) begin
                                o_q_pop = 1'b1;
                                n_cmd   = i_q_cmd;
                                load    = 1'b1;
                                n_word  = tkn_pkg::single_word(
                                    (i_q_cmd.flush == tkn_pkg::FL_NUM) ? tkn_pkg::KIND_NUM
                                                                       : tkn_pkg::KIND_WHILE,
                                    (i_q_cmd.flush == tkn_pkg::FL_NUM) ? i_q_cmd.number_value
                                                                       : 32'd0,
                                    8'd0, (i_q_cmd.tail == tkn_pkg::TL_NONE));
                                n_state = (i_q_cmd.tail == tkn_pkg::TL_NONE) ? tkn_pkg::BK_IDLE
                                                                             : tkn_pkg::BK_TAIL;
                            end
                        end
                        default: begin
                            if (slot_free) begin
                                o_q_pop = 1'b1;
                                load    = 1'b1;
                                n_word  = tkn_pkg::tail_word(i_q_cmd.tail, i_q_cmd.op_byte);
                            end
                        end
                    endcase
                end
            end
            tkn_pkg::BK_CHUNK: begin
                if (slot_free) begin
                    load               = 1'b1;
                    n_word             = '0;
                    n_word.token_kind  = tkn_pkg::KIND_ID;
                    n_word.text_chunk  = chunk;
                    n_word.chunk_bytes = cnt;
                    n_word.token_done  = last_chunk;
                    n_word.run_last    = last_chunk && (r_cmd.tail == tkn_pkg::TL_NONE);
                    if (last_chunk) begin
                        o_status.id_done = 1'b1;
                        n_state = (r_cmd.tail == tkn_pkg::TL_NONE) ? tkn_pkg::BK_IDLE
                                                                   : tkn_pkg::BK_TAIL;
                    end else begin
                        n_left   = r_left - LEN_W'(tkn_pkg::LANES);
                        n_row    = r_row + 1'b1;
                        o_rd_en  = 1'b1;
                        o_rd_row = r_row + 1'b1;
                    end
                end
            end
            tkn_pkg::BK_TAIL: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_word  = tkn_pkg::tail_word(r_cmd.tail, r_cmd.op_byte);
                    n_state = tkn_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = tkn_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkn_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_row  <= n_row;
        r_left <= n_left;
        r_word <= n_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_word;

endmodule

FILE: hw/rtl/byte_stream_tokenizer.sv
`timescale 1ns / 1ps
// ============================================================================
// Byte stream tokenizer
// Turns a stream of source bytes into number, name, keyword, operator and
// end-of-text tokens.
// ============================================================================
// Usage:
// Source bytes enter on the input channel (i_in_valid, o_in_stall, i_in_word),
// one word per byte. Tokens leave on the output channel (o_out_valid,
// i_out_stall, o_out_word); one input word may cause several output words,
// and run_last marks the last of them. A word is taken at a clock edge where
// valid is high and stall is low.
// Letters, digits and whitespace that only extend or start a token are taken
// one per cycle unless the input stalls, and cause no output. A byte that
// ends a token queues one command, which the back end pops and turns into
// registered output words. A number, keyword, operator or end token is one
// output word, sent one per cycle while the receiver does not stall. A name
// of n kept characters leaves as ceil(n/8) chunks once the buffer read is
// started; the name buffer is eight byte lanes, each a small RAM, so one row
// of eight characters, one chunk, is read per cycle while the receiver does not stall.
// The input stalls when the four-entry command queue is full, and when a new
// name would begin while the previous name is still being read out.
// When the receiver stalls, the output word holds, the queue fills, and then
// the input stalls. Reset empties the queue and the output register and
// leaves the scanner idle; no clearing pass is needed.
// ============================================================================
module byte_stream_tokenizer #(
    parameter int MAX_NAME_CHARS = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tkn_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tkn_pkg::t_out_word  o_out_word
);

    // The kept length is limited to 8..136 so that one byte never causes more
    // than eighteen output words.
    localparam int KEPT_CHARS = (MAX_NAME_CHARS < 8) ? 8 :
                                ((MAX_NAME_CHARS > 136) ? 136 : MAX_NAME_CHARS);
    localparam int LEN_W = $clog2(KEPT_CHARS + 1);
    localparam int ROWS  = (KEPT_CHARS + tkn_pkg::LANES - 1) / tkn_pkg::LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic                             q_push;
    logic                             q_pop;
    logic                             q_full;
    logic                             q_valid;
    tkn_pkg::t_cmd                    q_in_cmd;
    tkn_pkg::t_cmd                    q_out_cmd;
    logic                             id_busy;
    tkn_pkg::t_bk_status              bk_status;

    logic                             buf_wr_en;
    logic [LEN_W-1:0]                 buf_wr_idx;
    logic [7:0]                       buf_wr_data;
    logic [ROW_W-1:0]                 buf_wr_row;
    logic                             buf_rd_en;
    logic [ROW_W-1:0]                 buf_rd_row;
    logic [tkn_pkg::LANES-1:0][7:0]   buf_rd_data;

    tkn_front #(
        .KEPT_CHARS (KEPT_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd),
        .i_id_done  (bk_status.id_done),
        .o_id_busy  (id_busy),
        .o_wr_en    (buf_wr_en),
        .o_wr_idx   (buf_wr_idx),
        .o_wr_data  (buf_wr_data)
    );

    tkn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // Character k of a name sits in lane k mod 8, row k / 8.
    assign buf_wr_row = ROW_W'(buf_wr_idx >> 3);

    for (genvar l = 0; l < tkn_pkg::LANES; l++) begin : g_lane
        tkn_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (buf_wr_en && (buf_wr_idx[2:0] == 3'(l))),
            .i_wr_addr (buf_wr_row),
            .i_wr_data (buf_wr_data),
            .i_rd_en   (buf_rd_en),
            .i_rd_addr (buf_rd_row),
            .o_rd_data (buf_rd_data[l])
        );
    end

    tkn_back #(
        .KEPT_CHARS (KEPT_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_rd_en     (buf_rd_en),
        .o_rd_row    (buf_rd_row),
        .i_rd_data   (buf_rd_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_status    (bk_status)
    );

    // The front never queues a command into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // The name buffer is never written while a name is being read out.
    a_no_buf_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_wr_en |-> !bk_status.reading)
        else $error("name buffer written during readout");

    // Readout only happens while the front holds the buffer as busy.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_status.reading |-> id_busy)
        else $error("name readout without a pending name");

    // A name chunk always carries one to eight characters.
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.token_kind == tkn_pkg::KIND_ID) |->
        (o_out_word.chunk_bytes != 4'd0 && o_out_word.chunk_bytes <= 4'd8))
        else $error("name chunk with bad byte count");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Byte stream tokenizer testbench
// Sends source bytes to the tokenizer and checks every token word against a
// software scanner kept in step with the accepted bytes. A short directed
// part covers keywords, number wrap, end marks and odd operator bytes. Name
// lengths around the chunk size and the kept limit come next, then random
// text under three idle and stall profiles.
// ============================================================================
module testbench;

    // Kept-name limit as the block clamps it.
    localparam int NAME_CHARS = 63;
    localparam int NAME_KEPT  = (NAME_CHARS < 8) ? 8 :
                                ((NAME_CHARS > 136) ? 136 : NAME_CHARS);
    localparam logic [39:0] KEYWORD_TEXT = "while";
    // Cycles with no word moving on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 3000;
    // Quiet cycles after the last expected token, to catch stray output words.
    localparam int TAIL_CYCLES = 32;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    tkn_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tkn_pkg::t_out_word out_word;

    // Idle rates in percent for the source side and the token sink.
    int send_idle_pct = 14;
    int recv_idle_pct = 63;

    int bytes_sent    = 0;
    int words_checked = 0;
    int name_chunks   = 0;
    int end_marks     = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    // Scanner state mirrored from the accepted bytes.
    tkn_pkg::t_mode scan_state = tkn_pkg::MD_IDLE;
    logic [31:0]    num_acc    = '0;
    logic [7:0]     name_chars [0:NAME_KEPT-1];
    int             name_len   = 0;

    // Token words caused by the byte being scanned, and all words still owed.
    tkn_pkg::t_out_word item_tokens [$];
    tkn_pkg::t_out_word token_queue [$];

    byte_stream_tokenizer #(
        .MAX_NAME_CHARS(NAME_CHARS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Character classes, written out independently of the package helpers.
    // ------------------------------------------------------------------------
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic starts_name(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
    endfunction

    function automatic tkn_pkg::t_out_word token_word(input tkn_pkg::t_kind kind,
                                                      input logic [31:0] num,
                                                      input logic [7:0] op,
                                                      input logic [63:0] chunk,
                                                      input logic [3:0] cnt,
                                                      input logic done);
        tkn_pkg::t_out_word w;
        w               = '0;
        w.token_kind    = kind;
        w.number_value  = num;
        w.operator_byte = op;
        w.text_chunk    = chunk;
        w.chunk_bytes   = cnt;
        w.token_done    = done;
        return w;
    endfunction

    // Emits the pending number or name and returns the scanner to idle. A name
    // leaves as 8-character chunks, except an exact "while", which is the
    // keyword token.
    function automatic void flush_pending();
        logic [63:0] chunk;
        int          cnt;
        int          pos;
        int          i;
        if (scan_state == tkn_pkg::MD_NUM) begin
            item_tokens.push_back(token_word(tkn_pkg::KIND_NUM, num_acc, 8'd0, 64'd0,
                                             4'd0, 1'b1));
        end else if (scan_state == tkn_pkg::MD_ID) begin
            if (name_len == 5 && {name_chars[0], name_chars[1], name_chars[2],
                                  name_chars[3], name_chars[4]} == KEYWORD_TEXT) begin
                item_tokens.push_back(token_word(tkn_pkg::KIND_WHILE, 32'd0, 8'd0, 64'd0,
                                                 4'd0, 1'b1));
            end else begin
                for (pos = 0; pos < name_len; pos += 8) begin
                    cnt   = (name_len - pos < 8) ? name_len - pos : 8;
                    chunk = '0;
                    for (i = 0; i < cnt; i++) begin
                        chunk[8*i +: 8] = name_chars[pos + i];
                    end
                    item_tokens.push_back(token_word(tkn_pkg::KIND_ID, 32'd0, 8'd0, chunk,
                                                     4'(cnt), pos + cnt >= name_len));
                end
            end
        end
        scan_state = tkn_pkg::MD_IDLE;
        num_acc    = '0;
        name_len   = 0;
    endfunction

    // Advances the scanner by one accepted word and queues the token words it
    // causes, with run_last on the final one.
    function automatic void scan_byte(input tkn_pkg::t_in_word w);
        logic [7:0]         c;
        tkn_pkg::t_out_word last_word;
        c = w.text_byte;
        item_tokens.delete();
        if (w.end_of_text || c == 8'd0) begin
            flush_pending();
            item_tokens.push_back(token_word(tkn_pkg::KIND_EOF, 32'd0, 8'd0, 64'd0,
                                             4'd0, 1'b1));
        end else if (scan_state == tkn_pkg::MD_NUM && is_numeral(c)) begin
            num_acc = num_acc * 32'd10 + {24'd0, 8'(c - tkn_pkg::CHAR_ZERO)};
        end else if (scan_state == tkn_pkg::MD_ID && (starts_name(c) || is_numeral(c))) begin
            // Characters past the kept limit are swallowed.
            if (name_len < NAME_KEPT) begin
                name_chars[name_len] = c;
                name_len++;
            end
        end else begin
            // The byte ends any pending token and is then scanned afresh.
            flush_pending();
            if (!is_blank(c)) begin
                if (is_numeral(c)) begin
                    scan_state = tkn_pkg::MD_NUM;
                    num_acc    = {24'd0, 8'(c - tkn_pkg::CHAR_ZERO)};
                end else if (starts_name(c)) begin
                    scan_state    = tkn_pkg::MD_ID;
                    name_chars[0] = c;
                    name_len      = 1;
                end else begin
                    item_tokens.push_back(token_word(tkn_pkg::KIND_OP, 32'd0, c, 64'd0,
                                                     4'd0, 1'b1));
                end
            end
        end
        if (item_tokens.size() > 0) begin
            last_word          = item_tokens.pop_back();
            last_word.run_last = 1'b1;
            item_tokens.push_back(last_word);
            foreach (item_tokens[k]) token_queue.push_back(item_tokens[k]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Source side. Valid stays high from one word to the next unless an idle
    // cycle is drawn, so it is never lowered and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eot);
        tkn_pkg::t_in_word w;
        w.text_byte   = b;
        w.end_of_text = eot;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        scan_byte(w);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) send_byte(s[i], 1'b0);
    endtask

    // Valid is dropped before any pause so that a held word is not taken twice.
    task automatic set_idling(input int send_pct, input int recv_pct);
        in_valid <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    function automatic logic [7:0] name_head_char();
        int r;
        r = $urandom_range(52);
        if (r == 52) return 8'h5F;
        return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
    endfunction

    function automatic logic [7:0] name_tail_char();
        if ($urandom_range(5) == 0) return 8'(8'h30 + $urandom_range(9));
        return name_head_char();
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    // ------------------------------------------------------------------------
    // Sink side: random stalls, then every accepted word is checked against
    // the oldest token word owed.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("token word %0d %s: got 0x%0h, expected 0x%0h",
                                      words_checked, field, got, want));
        end
    endtask

    always @(posedge clk) begin
        tkn_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (token_queue.size() == 0) begin
                report_mismatch($sformatf("token word %0d (kind %0d) with nothing owed",
                                          words_checked, out_word.token_kind));
            end else begin
                want = token_queue.pop_front();
                check_field("token_kind",    out_word.token_kind,    want.token_kind);
                check_field("number_value",  out_word.number_value,  want.number_value);
                check_field("operator_byte", out_word.operator_byte, want.operator_byte);
                check_field("text_chunk",    out_word.text_chunk,    want.text_chunk);
                check_field("chunk_bytes",   out_word.chunk_bytes,   want.chunk_bytes);
                check_field("token_done",    out_word.token_done,    want.token_done);
                check_field("run_last",      out_word.run_last,      want.run_last);
                if (want.token_kind == tkn_pkg::KIND_ID) name_chunks++;
                if (want.token_kind == tkn_pkg::KIND_EOF) end_marks++;
            end
            words_checked++;
        end
    end

    // Watchdog: a hang shows up as a long stretch with no word moving.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Keyword, near-miss keyword, a number flushed by a letter, a number that
    // wraps past 2^32, both kinds of end mark (with and without a pending
    // token) and operator bytes at the edges of the byte range.
    task automatic test_directed_tokens();
        send_text("while;");
        send_text("whil\t7a");
        send_byte(8'hFF, 1'b1);
        send_text("4294967296");
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    // Names of random content of keyword length, on the chunk boundary, just
    // past it, and past the kept limit, each ended a different way.
    task automatic test_name_lengths();
        int lengths [4];
        int n;
        int k;
        lengths = '{5, 8, 9, NAME_KEPT + 1};
        for (n = 0; n < 4; n++) begin
            send_byte(name_head_char(), 1'b0);
            for (k = 1; k < lengths[n]; k++) send_byte(name_tail_char(), 1'b0);
            case (n)
                0:       send_byte(blank_char(), 1'b0);
                1:       send_byte(8'h2B, 1'b0);
                2:       send_byte(8'h00, 1'b0);
                default: send_byte(8'h3C, 1'b1);
            endcase
        end
    endtask

    // Random text built mostly from well-formed tokens, with some noise bytes
    // and end marks mixed in.
    task automatic test_random_text(input int n_bytes);
        int first;
        int pick;
        int len;
        int k;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(7) == 0) begin
                    send_text("while");
                end else begin
                    len = $urandom_range(1, 20);
                    send_byte(name_head_char(), 1'b0);
                    for (k = 1; k < len; k++) send_byte(name_tail_char(), 1'b0);
                end
            end else if (pick < 58) begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++) send_byte(8'(8'h30 + $urandom_range(9)), 1'b0);
            end else if (pick < 75) begin
                send_byte(8'($urandom_range(1, 255)), 1'b0);
            end else if (pick < 88) begin
                send_byte(blank_char(), 1'b0);
            end else if (pick < 94) begin
                if ($urandom_range(1) == 1) begin
                    send_byte(8'($urandom_range(255)), 1'b1);
                end else begin
                    send_byte(8'h00, 1'b0);
                end
            end else begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Slow sink first, then a slow source, then both at full rate.
        test_directed_tokens();
        test_name_lengths();
        test_random_text(46);
        set_idling(63, 14);
        test_random_text(46);
        set_idling(0, 0);
        test_random_text(46);

        in_valid <= 1'b0;
        while (token_queue.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (token_queue.size() != 0) begin
            report_mismatch($sformatf("%0d token words never arrived", token_queue.size()));
        end

        $display("Run covered %0d source bytes and %0d token words (%0d name chunks, %0d end marks),",
                 bytes_sent, words_checked, name_chunks, end_marks);
        $display("under slow-sink, slow-source and full-rate traffic; %0d mismatches.",
                 error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
